/* rtl/mlfr_pkg.sv */
`timescale 1ns / 1ps

package mlfr_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned LINK_W        = 2;
   localparam int unsigned LEN_W         = 6;
   localparam int unsigned HEADER_BYTES  = 8;   // start byte, six header fields, length byte
   localparam int unsigned START_POS     = 0;
   localparam int unsigned LENGTH_POS    = 7;
   localparam int unsigned HEADER_FIELDS = 6;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_START,
      ST_CHK_LEN,
      ST_HDR,
      ST_OUT_LOAD,
      ST_OUT_WAIT
   } state_type;

   // Result payload, last field in the lowest bits.
   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [LEN_W-1:0]  payload_length;
      logic [BYTE_W-1:0] msg_kind;
      logic [BYTE_W-1:0] ack_code;
      logic [BYTE_W-1:0] command_code;
      logic [BYTE_W-1:0] child_index;
      logic [BYTE_W-1:0] destination_id;
      logic [BYTE_W-1:0] sender_id;
      logic [LINK_W-1:0] frame_link;
   } rsp_type;

   localparam int unsigned RSP_DATA_W = $bits(rsp_type);

endpackage

/* rtl/mlfr_buffer_mem.sv */
`timescale 1ns / 1ps

module mlfr_buffer_mem
   import mlfr_pkg::*;
#(
   parameter int unsigned DEPTH = 192
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [BYTE_W-1:0]          wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [BYTE_W-1:0]          rd_data
);

   logic [BYTE_W-1:0] buffer_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buffer_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= buffer_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mlfr_sequencer.sv */
`timescale 1ns / 1ps

module mlfr_sequencer
   import mlfr_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 64,
   parameter int unsigned LINK_COUNT   = 3
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   input  logic [BYTE_W-1:0]                             req_tdata,
   input  logic [LINK_W-1:0]                             req_tuser,
   input  logic [BYTE_W-1:0]                             start_marker,
   output logic                                          mem_wr_en,
   output logic [$clog2(LINK_COUNT*BUFFER_BYTES)-1:0]    mem_wr_addr,
   output logic [BYTE_W-1:0]                             mem_wr_data,
   output logic [$clog2(LINK_COUNT*BUFFER_BYTES)-1:0]    mem_rd_addr,
   input  logic [BYTE_W-1:0]                             mem_rd_data,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [RSP_DATA_W-1:0]                         rsp_tdata,
   output logic                                          rsp_tuser,
   output logic                                          rsp_tlast
);

   localparam int unsigned DEPTH  = LINK_COUNT * BUFFER_BYTES;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned POS_W  = $clog2(BUFFER_BYTES);
   localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES + 1);
   localparam int unsigned SLOT_W = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
   localparam int unsigned CMP_W  = BYTE_W + 1;

   // map a logical buffer position onto the ring, starting at the head
   function automatic logic [POS_W-1:0] ring_pos(input logic [POS_W-1:0] head,
                                                 input logic [POS_W-1:0] pos);
      logic [POS_W:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (POS_W+1)'(BUFFER_BYTES)) begin
         sum = sum - (POS_W+1)'(BUFFER_BYTES);
      end
      return sum[POS_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] mem_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [POS_W-1:0]  pos);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(slot) * ADDR_W'(BUFFER_BYTES);
      return base + ADDR_W'(pos);
   endfunction

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  idx_ff  [LINK_COUNT];
   logic [CNT_W-1:0]  idx_in  [LINK_COUNT];
   logic [POS_W-1:0]  head_ff [LINK_COUNT];
   logic [POS_W-1:0]  head_in [LINK_COUNT];

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LINK_W-1:0] link_ff, link_in;
   logic [POS_W-1:0]  head_cur_ff, head_cur_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  item_ff, item_in;
   logic [BYTE_W-1:0] hdr_ff [HEADER_FIELDS];
   logic [BYTE_W-1:0] hdr_in [HEADER_FIELDS];
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_user_ff, rsp_user_in;

   logic              link_ok;
   logic [SLOT_W-1:0] req_slot;
   logic [CNT_W-1:0]  cur_idx;
   logic [POS_W-1:0]  cur_head;
   logic [POS_W-1:0]  wr_pos;
   logic [CNT_W-1:0]  n_new;
   logic              accept;
   logic              start_ok;
   logic              frame_done;
   logic              last_item;
   logic [SLOT_W-1:0] rd_slot;
   logic [POS_W-1:0]  rd_head;
   logic [POS_W-1:0]  rd_pos;

   assign link_ok  = (req_tuser != '0) && ({1'b0, req_tuser} <= (LINK_W+1)'(LINK_COUNT));
   assign req_slot = SLOT_W'(req_tuser - 1'b1);
   assign cur_idx  = idx_ff[req_slot];
   assign cur_head = head_ff[req_slot];
   // wrap a full buffer before the byte is stored
   assign wr_pos   = (cur_idx >= CNT_W'(BUFFER_BYTES)) ? '0 : POS_W'(cur_idx);
   assign n_new    = CNT_W'(wr_pos) + 1'b1;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready && link_ok;

   assign start_ok   = (mem_rd_data == start_marker);
   assign frame_done = (CMP_W'(cnt_ff) >= (CMP_W'(HEADER_BYTES) + CMP_W'(mem_rd_data)));
   assign last_item  = (len_ff == '0) || (LEN_W'(item_ff + 1'b1) == len_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (n_new >= CNT_W'(HEADER_BYTES))) begin
               state_in = ST_CHK_START;
            end
         end
         ST_CHK_START: begin
            state_in = start_ok ? ST_CHK_LEN : ST_IDLE;
         end
         ST_CHK_LEN: begin
            state_in = frame_done ? ST_HDR : ST_IDLE;
         end
         ST_HDR: begin
            if (pos_ff == POS_W'(HEADER_FIELDS)) begin
               state_in = ST_OUT_LOAD;
            end
         end
         ST_OUT_LOAD: begin
            state_in = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (rsp_tready) begin
               state_in = rsp_last_ff ? ST_IDLE : ST_OUT_LOAD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // read position for the byte needed in the next state
   always_comb begin
      rd_slot = slot_ff;
      rd_head = head_cur_ff;
      rd_pos  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_slot = req_slot;
            rd_head = cur_head;
            rd_pos  = POS_W'(START_POS);
         end
         ST_CHK_START: begin
            rd_pos = POS_W'(LENGTH_POS);
         end
         ST_CHK_LEN: begin
            rd_pos = POS_W'(1);
         end
         ST_HDR: begin
            rd_pos = (pos_ff == POS_W'(HEADER_FIELDS)) ? POS_W'(HEADER_BYTES)
                                                      : POS_W'(pos_ff + 1'b1);
         end
         ST_OUT_LOAD, ST_OUT_WAIT: begin
            rd_pos = POS_W'(HEADER_BYTES) + POS_W'(item_ff) + POS_W'(1);
         end
         default: begin
            rd_pos = '0;
         end
      endcase
   end

   assign mem_rd_addr = mem_addr(rd_slot, ring_pos(rd_head, rd_pos));
   assign mem_wr_addr = mem_addr(req_slot, ring_pos(cur_head, wr_pos));
   assign mem_wr_data = req_tdata;

   // datapath and per-link state updates
   always_comb begin
      mem_wr_en    = 1'b0;
      idx_in       = idx_ff;
      head_in      = head_ff;
      slot_in      = slot_ff;
      link_in      = link_ff;
      head_cur_in  = head_cur_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      item_in      = item_ff;
      hdr_in       = hdr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mem_wr_en         = 1'b1;
               idx_in[req_slot]  = n_new;
               slot_in           = req_slot;
               link_in           = req_tuser;
               head_cur_in       = cur_head;
               cnt_in            = n_new;
            end
         end
         ST_CHK_START: begin
            if (!start_ok) begin
               // slide: advance the ring head by one byte
               head_in[slot_ff] = ring_pos(head_cur_ff, POS_W'(1));
               idx_in[slot_ff]  = CNT_W'(cnt_ff - 1'b1);
            end
         end
         ST_CHK_LEN: begin
            if (frame_done) begin
               len_in          = LEN_W'(mem_rd_data);
               idx_in[slot_ff] = '0;
               pos_in          = POS_W'(1);
               item_in         = '0;
            end
         end
         ST_HDR: begin
            for (int k = 0; k < HEADER_FIELDS - 1; k++) begin
               hdr_in[k] = hdr_ff[k+1];
            end
            hdr_in[HEADER_FIELDS-1] = mem_rd_data;
            pos_in = POS_W'(pos_ff + 1'b1);
         end
         ST_OUT_LOAD: begin
            rsp_in.frame_link     = link_ff;
            rsp_in.sender_id      = hdr_ff[0];
            rsp_in.destination_id = hdr_ff[1];
            rsp_in.child_index    = hdr_ff[2];
            rsp_in.command_code   = hdr_ff[3];
            rsp_in.ack_code       = hdr_ff[4];
            rsp_in.msg_kind       = hdr_ff[5];
            rsp_in.payload_length = len_ff;
            rsp_in.payload_byte   = (len_ff == '0) ? '0 : mem_rd_data;
            rsp_user_in           = (len_ff != '0);
            rsp_last_in           = last_item;
            rsp_valid_in          = 1'b1;
         end
         ST_OUT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               item_in      = LEN_W'(item_ff + 1'b1);
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < LINK_COUNT; k++) begin
            idx_ff[k]  <= '0;
            head_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         head_ff      <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      link_ff     <= link_in;
      head_cur_ff <= head_cur_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      item_ff     <= item_in;
      hdr_ff      <= hdr_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* rtl/multi_link_frame_receiver_top.sv */
`timescale 1ns / 1ps

// Multi-link frame receiver. Bytes arrive one transaction at a time, each
// tagged with a link number (1 to LINK_COUNT; any other number is dropped
// without effect). Every link keeps its own BUFFER_BYTES ring in a shared
// single-write, single-read synchronous memory with a registered read; a
// per-link fill count and ring head live in flip-flops, so sliding the
// buffer down by one byte is a head advance, never a copy. A frame is
// the start marker (csr register), six header bytes, a length byte and
// that many payload bytes; a completed frame comes out as one result
// transaction per payload byte, or one result with tuser low for an
// empty payload, and tlast marks the final one. Each input byte is
// stored; once the link holds eight bytes or more, the start byte is read
// back and, if it does not match, the buffer slides; else the length is
// read back as well, and for a completing byte the six header bytes are
// read and the results sent out, waiting whenever the result side stalls.
// All reads go through the one memory read port, which the sequencer
// walks one byte at a time. One byte or frame is processed at a time:
// req_tready is low until the last result is taken. The buffer memory
// needs no clearing pass after reset.

module multi_link_frame_receiver_top
   import mlfr_pkg::*;
#(
   parameter int unsigned BUFFER_BYTES = 64,
   parameter int unsigned LINK_COUNT   = 3
) (
   input  logic                  clock,
   input  logic                  reset,
   // input byte channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,    // [7:0] rx_byte
   input  logic [LINK_W-1:0]     req_tuser,    // [1:0] link_number
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] frame_link, [9:2] sender_id, [17:10] destination_id,
   // [25:18] child_index, [33:26] command_code, [41:34] ack_code,
   // [49:42] msg_kind, [55:50] payload_length, [63:56] payload_byte
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,    // [0] payload_valid
   output logic                  rsp_tlast,    // last_of_frame
   // start marker register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BYTE_W-1:0]     csr_data
);

   localparam int unsigned DEPTH  = LINK_COUNT * BUFFER_BYTES;
   localparam int unsigned ADDR_W = $clog2(DEPTH);

   logic [BYTE_W-1:0] start_marker_ff, start_marker_in;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;

   // register writes are always taken; the user must write only while the block is idle (not enforced here)
   assign csr_ready       = 1'b1;
   assign start_marker_in = (csr_valid && csr_ready) ? csr_data : start_marker_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= '0;
      end else begin
         start_marker_ff <= start_marker_in;
      end
   end

   // per-link byte rings
   mlfr_buffer_mem #(
      .DEPTH (DEPTH)
   ) u_buffer_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // store, start check, slide, header fetch and result readout
   mlfr_sequencer #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .LINK_COUNT   (LINK_COUNT)
   ) u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .start_marker (start_marker_ff),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

   // no new byte is taken while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input accepted while a result is pending");

   // an empty payload gives exactly one result, with a zero data byte
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && (rsp_tdata[63:56] == 8'd0)))
      else $error("empty-payload result not single or not zeroed");

   // results only name a link that exists
   a_link_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[1:0] != 2'd0) &&
                      ({1'b0, rsp_tdata[1:0]} <= 3'(LINK_COUNT))))
      else $error("result carries an invalid link number");

   // a byte on a nonexistent link is dropped without leaving idle
   a_bad_link_drop: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       ((req_tuser == 2'd0) || ({1'b0, req_tuser} > 3'(LINK_COUNT))))
      |=> req_tready)
      else $error("byte on an invalid link started processing");

endmodule
